/* rtl/core/bidst_pkg.sv */
// shared types and constants for the beacon identifier status table
`default_nettype none

package bidst_pkg;

   localparam logic [7:0] BEACON_TYPE = 8'hC0;
   localparam logic [7:0] MIN_LENGTH  = 8'd3;

   typedef struct packed {
      logic [7:0] packet_length;
      logic [7:0] message_type;
      logic [7:0] beacon_id;
      logic [7:0] led_status;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       trigger_capture;
      logic [2:0] slot_index;
      logic       was_new;
      logic       dropped_full;
      logic [7:0] previous_status;
      logic [3:0] entry_count;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/beacon_id_status_table_top.sv */
// beacon identifier status table: match-or-append table with one result per message
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------
//  req     | in        | req_valid / req_ready  | bidst_pkg::req_type
//  rsp     | out       | rsp_valid / rsp_ready  | bidst_pkg::rsp_type
//  csr     | in        | csr_wr_en, no wait     | csr_wr_data (capture_on_led)
//
// the identifier is compared against every table entry in parallel, and the table
// and the result register update on the same edge
// a new transaction is taken every cycle while the result register is empty or drained
// the result register holds its transaction while rsp_ready is low, and req_ready drops
// reset (synchronous, active high) clears the entry count, the result valid and the
// capture mode; table contents are left as they are since only used entries are read
`default_nettype none

module beacon_id_status_table_top #(
   parameter int TABLE_DEPTH = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire bidst_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output bidst_pkg::rsp_type rsp_data,
   input  wire                csr_wr_en,
   input  wire                csr_wr_data
);

   // index and count widths follow the table depth
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // table storage; entries at or above the count are never looked at
   logic [7:0] id_store_ff     [TABLE_DEPTH];
   logic [7:0] status_store_ff [TABLE_DEPTH];

   logic [CNT_W-1:0]   used_count_ff, used_count_in;
   logic               capture_on_led_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bidst_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                   take;
   logic                   acc;
   logic                   full;
   logic                   found;
   logic [TABLE_DEPTH-1:0] hit;
   logic [TABLE_DEPTH-1:0] upd_we;
   logic [TABLE_DEPTH-1:0] new_we;
   logic [IDX_W-1:0]       hit_idx;
   logic [7:0]             hit_status;
   logic [IDX_W-1:0]       slot;
   logic [IDX_W+2:0]       slot_ext;
   logic [CNT_W+3:0]       count_ext;

   // result register frees up when it is empty or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   assign acc  = (req_data.message_type == bidst_pkg::BEACON_TYPE) &&
                 (req_data.packet_length >= bidst_pkg::MIN_LENGTH);
   assign full = (used_count_ff == CNT_W'(TABLE_DEPTH));

   // parallel compare; stored identifiers are distinct, so at most one entry hits
   // and the hit index and status can be gathered by a plain or of masked entries
   always_comb begin
      hit_idx    = '0;
      hit_status = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i] = (CNT_W'(i) < used_count_ff) && (id_store_ff[i] == req_data.beacon_id);
         if (hit[i]) begin
            hit_idx    = hit_idx | IDX_W'(i);
            hit_status = hit_status | status_store_ff[i];
         end
      end
      found = |hit;
   end

   // per-entry write enables: update a matched entry or append at the count
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         upd_we[i] = take && acc && hit[i];
         new_we[i] = take && acc && !found && !full && (used_count_ff == CNT_W'(i));
      end
   end

   always_comb begin
      slot          = '0;
      used_count_in = used_count_ff;
      rsp_data_in   = '0;
      if (acc) begin
         if (found) begin
            slot = hit_idx;
         end else if (!full) begin
            slot          = used_count_ff[IDX_W-1:0];
            used_count_in = used_count_ff + CNT_W'(1);
         end
      end
      slot_ext  = {3'b000, slot};
      count_ext = {4'b0000, used_count_in};

      rsp_data_in.accepted        = acc;
      rsp_data_in.trigger_capture = acc && capture_on_led_ff;
      rsp_data_in.slot_index      = slot_ext[2:0];
      rsp_data_in.was_new         = acc && !found && !full;
      rsp_data_in.dropped_full    = acc && !found && full;
      rsp_data_in.previous_status = (acc && found) ? hit_status : 8'd0;
      rsp_data_in.entry_count     = count_ext[3:0];

      // result valid: loaded by a new transaction, cleared once taken downstream
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff     <= '0;
         capture_on_led_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            used_count_ff <= used_count_in;
         end
         if (csr_wr_en) begin
            capture_on_led_ff <= csr_wr_data;
         end
      end
   end

   // payload registers and table entries, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (new_we[i]) begin
            id_store_ff[i] <= req_data.beacon_id;
         end
         if (upd_we[i] || new_we[i]) begin
            status_store_ff[i] <= req_data.led_status;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/bidst_checker.sv */
// port-level checks for the beacon identifier status table, bound to the top level
`default_nettype none

module bidst_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire bidst_pkg::req_type req_data,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire bidst_pkg::rsp_type rsp_data
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a full result register with no drain blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // every accepted transaction shows up as a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // a message of the wrong type is never marked accepted
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.message_type != bidst_pkg::BEACON_TYPE)
      |=> !rsp_data.accepted && !rsp_data.trigger_capture)
      else $error("wrong message type accepted");

   // a new entry raises the count, so it can never be zero, and it is never flagged as dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_new |-> (rsp_data.entry_count != 4'd0) &&
      !rsp_data.dropped_full)
      else $error("new entry with bad count or drop flag");

endmodule

bind beacon_id_status_table_top bidst_checker u_bidst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* bench/bidst_result_checker.sv */
// result checker for the beacon identifier status table: predicts each result and compares it
`timescale 1ns / 100ps

module bidst_result_checker #(
   parameter int TABLE_DEPTH = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  bidst_pkg::req_type req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  bidst_pkg::rsp_type rsp_data,
   input  wire                csr_wr_en,
   input  wire                csr_wr_data,
   output int                 error_count,
   output int                 pending_count,
   output int                 checked_count,
   output int                 match_count,
   output int                 drop_count
);

   // mirror of the table and the capture mode
   logic [7:0] id_table [TABLE_DEPTH];
   logic [7:0] status_table [TABLE_DEPTH];
   logic [7:0] old_status_table [TABLE_DEPTH];
   int         used_entries;
   logic       capture_mode;

   bidst_pkg::rsp_type beacon_results_due[$];
   int         errors;
   int         checked;
   int         updates;
   int         drops;

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
      match_count   = 0;
      drop_count    = 0;
      errors        = 0;
      checked       = 0;
      updates       = 0;
      drops         = 0;
      used_entries  = 0;
      capture_mode  = 1'b0;
   end

   // applies one message to the mirrored table and returns the result it should give
   function automatic bidst_pkg::rsp_type update_beacon_table(bidst_pkg::req_type msg);
      bidst_pkg::rsp_type r;
      int      hit;
      r   = '0;
      hit = -1;
      if (msg.message_type == bidst_pkg::BEACON_TYPE &&
          msg.packet_length >= bidst_pkg::MIN_LENGTH) begin
         r.accepted        = 1'b1;
         r.trigger_capture = capture_mode;
         for (int i = 0; i < used_entries; i++)
            if (hit < 0 && id_table[i] == msg.beacon_id) hit = i;
         if (hit >= 0) begin
            r.slot_index          = 3'(hit);
            r.previous_status     = status_table[hit];
            old_status_table[hit] = status_table[hit];
            status_table[hit]     = msg.led_status;
         end else if (used_entries < TABLE_DEPTH) begin
            id_table[used_entries]     = msg.beacon_id;
            status_table[used_entries] = msg.led_status;
            r.slot_index               = 3'(used_entries);
            r.was_new                  = 1'b1;
            used_entries++;
         end else begin
            r.dropped_full = 1'b1;
         end
      end
      r.entry_count = 4'(used_entries);
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("%t error: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("result %0d field %s: got %0h, expected %0h",
                                checked, name, got, want));
   endtask

   always @(posedge clock) begin
      bidst_pkg::rsp_type want;
      bidst_pkg::rsp_type r;
      if (reset) begin
         used_entries = 0;
         capture_mode = 1'b0;
         beacon_results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            r = rsp_data;
            if (beacon_results_due.size() == 0) begin
               report_error($sformatf("result with nothing outstanding: %h", r));
            end else begin
               want = beacon_results_due.pop_front();
               check_field("accepted", 8'(r.accepted), 8'(want.accepted));
               check_field("trigger_capture", 8'(r.trigger_capture), 8'(want.trigger_capture));
               check_field("slot_index", 8'(r.slot_index), 8'(want.slot_index));
               check_field("was_new", 8'(r.was_new), 8'(want.was_new));
               check_field("dropped_full", 8'(r.dropped_full), 8'(want.dropped_full));
               check_field("previous_status", r.previous_status, want.previous_status);
               check_field("entry_count", 8'(r.entry_count), 8'(want.entry_count));
               if (want.accepted && !want.was_new && !want.dropped_full) updates++;
               if (want.dropped_full) drops++;
            end
            checked++;
         end
         if (csr_wr_en) capture_mode = csr_wr_data;
         if (req_valid && req_ready)
            beacon_results_due.push_back(update_beacon_table(req_data));
      end
      error_count   <= errors;
      pending_count <= beacon_results_due.size();
      checked_count <= checked;
      match_count   <= updates;
      drop_count    <= drops;
   end

endmodule

/* bench/beacon_id_status_table_top_tb.sv */
// testbench top for the beacon identifier status table: stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module beacon_id_status_table_top_tb;

   localparam int RANDOM_ITEMS = 1952;    // split over four capture mode phases
   localparam int CYCLE_LIMIT  = 500000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   bidst_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   bidst_pkg::rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   int error_count;
   int pending_count;
   int checked_count;
   int match_count;
   int drop_count;

   int   cycle_count    = 0;
   int   messages_sent  = 0;
   int   directed_sent  = 0;
   int   config_writes  = 0;
   bit   req_eager      = 1'b0;
   bit   rsp_eager      = 1'b0;

   // identifiers the directed part loads into the table, in slot order
   logic [7:0] table_ids [8];

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   beacon_id_status_table_top #(
      .TABLE_DEPTH (8)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // the checker mirrors the table, predicts every result and counts mismatches
   bidst_result_checker #(
      .TABLE_DEPTH (8)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .match_count   (match_count),
      .drop_count    (drop_count)
   );

   // watchdog: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic bidst_pkg::req_type beacon_msg(input logic [7:0] len,
                                                     input logic [7:0] kind,
                                                     input logic [7:0] id,
                                                     input logic [7:0] led);
      bidst_pkg::req_type m;
      m.packet_length = len;
      m.message_type  = kind;
      m.beacon_id     = id;
      m.led_status    = led;
      return m;
   endfunction

   // mostly well-formed beacon messages aimed at known identifiers, with
   // unknown identifiers (dropped once the table is full) and rejected noise mixed in
   function automatic bidst_pkg::req_type random_beacon();
      bidst_pkg::req_type m;
      int unsigned pick;
      logic [7:0]  len;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       len = bidst_pkg::MIN_LENGTH;
         1:       len = 8'd250;
         default: len = 8'($urandom_range(3, 250));
      endcase
      m = beacon_msg(len, bidst_pkg::BEACON_TYPE, 8'($urandom), 8'($urandom));
      if (pick < 55) begin
         m.beacon_id = table_ids[$urandom_range(0, 7)];
      end else if (pick < 75) begin
         // random identifier, usually not in the table
      end else if (pick < 85) begin
         // wrong type byte, any length from 0 to 250
         m.message_type = 8'($urandom);
         if (m.message_type == bidst_pkg::BEACON_TYPE) m.message_type = ~bidst_pkg::BEACON_TYPE;
         m.packet_length = 8'($urandom_range(0, 250));
      end else if (pick < 93) begin
         // beacon type but too short to hold the status byte
         m.packet_length = 8'($urandom_range(0, 2));
      end else begin
         // fully random header, occasionally a valid one
         m.message_type  = 8'($urandom);
         m.packet_length = 8'($urandom_range(0, 250));
      end
      return m;
   endfunction

   // one transaction on the request channel; valid stays high across back-to-back items
   task automatic send_message(input bidst_pkg::req_type m);
      int gap;
      if ($urandom_range(0, 49) == 0) req_eager = !req_eager;
      gap = req_eager ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
      messages_sent++;
   endtask

   // capture mode only changes while the table has nothing in flight
   task automatic write_capture_mode(input logic mode);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      config_writes++;
   endtask

   // result side: random stalls per transaction, with stretches of no back-pressure
   initial begin : rsp_drain
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_eager = !rsp_eager;
         stall = rsp_eager ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      table_ids = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'h3C};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rejected messages on an empty table: short, wrong type, zero length, null type
      send_message(beacon_msg(8'd2,   bidst_pkg::BEACON_TYPE, 8'h00, 8'h12));
      send_message(beacon_msg(8'd250, 8'hC1,                  8'hFF, 8'hFF));
      send_message(beacon_msg(8'd0,   bidst_pkg::BEACON_TYPE, 8'h00, 8'h00));
      send_message(beacon_msg(8'd3,   8'h00,                  8'h5A, 8'h34));

      // first entries at the length extremes, then an update of slot 0
      send_message(beacon_msg(bidst_pkg::MIN_LENGTH, bidst_pkg::BEACON_TYPE, table_ids[0], 8'h00));
      send_message(beacon_msg(8'd250,                bidst_pkg::BEACON_TYPE, table_ids[1], 8'hFF));
      send_message(beacon_msg(bidst_pkg::MIN_LENGTH, bidst_pkg::BEACON_TYPE, table_ids[0], 8'hA5));

      // fill the remaining slots
      for (int i = 2; i < 8; i++)
         send_message(beacon_msg(8'(3 + i), bidst_pkg::BEACON_TYPE, table_ids[i],
                                 8'(8'h11 * i)));

      // full table: unknown identifier dropped, last slot still updated, noise ignored
      send_message(beacon_msg(8'd100, bidst_pkg::BEACON_TYPE, 8'hC3,        8'h99));
      send_message(beacon_msg(8'd4,   bidst_pkg::BEACON_TYPE, table_ids[7], 8'h55));
      send_message(beacon_msg(8'd250, 8'hFF,                  table_ids[3], 8'hEE));

      // capture mode on: trigger only on accepted messages
      write_capture_mode(1'b1);
      send_message(beacon_msg(bidst_pkg::MIN_LENGTH, bidst_pkg::BEACON_TYPE, table_ids[1], 8'h00));
      send_message(beacon_msg(8'd50,                 bidst_pkg::BEACON_TYPE, 8'hC3,        8'h01));
      send_message(beacon_msg(8'd2,                  bidst_pkg::BEACON_TYPE, table_ids[2], 8'h02));
      send_message(beacon_msg(8'd200,                8'h7F,                  table_ids[4], 8'h03));
      directed_sent = messages_sent;

      // random part, capture mode alternating off and on between phases
      for (int phase = 0; phase < 4; phase++) begin
         write_capture_mode(phase[0]);
         repeat (RANDOM_ITEMS / 4) send_message(random_beacon());
      end

      // drain: every expected result has to arrive before the verdict
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);

      $display("sent %0d beacon messages (%0d directed) over %0d capture mode settings",
               messages_sent, directed_sent, config_writes + 1);
      $display("checked %0d results: %0d status updates, %0d dropped on a full table",
               checked_count, match_count, drop_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/bidst_pkg.sv
rtl/core/beacon_id_status_table_top.sv
rtl/core/bidst_checker.sv
bench/bidst_result_checker.sv
bench/beacon_id_status_table_top_tb.sv
